@@ rtl/rbtd_pkg.sv @@
// ----------------------------------------------------------------------------
// rbtd_pkg
// Types, status codes and BCD helpers for the RTC BCD time check and decode.
// ----------------------------------------------------------------------------
package rbtd_pkg;

	// Summary code, lowest value has the highest priority
	typedef enum logic [2:0] {
		ST_ABSENT   = 3'd0,
		ST_READ_ERR = 3'd1,
		ST_OSC_STOP = 3'd2,
		ST_12H_MODE = 3'd3,
		ST_DEC_ERR  = 3'd4,
		ST_OK       = 3'd5
	} rbtd_status_t;

	localparam logic [11:0] YEAR_BASE = 12'd2000;

	// One clock snapshot, fields in transaction order
	typedef struct packed {
		logic       device_present;
		logic       status_read_ok;
		logic       time_read_ok;
		logic [7:0] status_byte;
		logic [7:0] seconds_raw;
		logic [7:0] minutes_raw;
		logic [7:0] hours_raw;
		logic [7:0] weekday_raw;
		logic [7:0] date_raw;
		logic [7:0] month_raw;
		logic [7:0] year_raw;
	} rbtd_in_t;

	typedef struct packed {
		rbtd_status_t status_code;
		logic         time_valid;
		logic [11:0]  year_out;
		logic [3:0]   month_out;
		logic [4:0]   date_out;
		logic [4:0]   hour_out;
		logic [5:0]   minute_out;
		logic [5:0]   second_out;
	} rbtd_out_t;

	// Two BCD digits to binary; tens*10 as (x<<3)+(x<<1). Max 15*10+15 = 165.
	function automatic logic [7:0] bcd_value(input logic [7:0] v);
		logic [7:0] hi;
		logic [7:0] lo;
		hi = {4'b0000, v[7:4]};
		lo = {4'b0000, v[3:0]};
		return (hi << 3) + (hi << 1) + lo;
	endfunction

	// Units digit a decimal digit, tens within limit, value within limit
	function automatic logic bcd_ok(input logic [7:0] v, input logic [3:0] max_tens,
			input logic [7:0] max_val);
		return (v[3:0] <= 4'd9) && (v[7:4] <= max_tens) && (bcd_value(v) <= max_val);
	endfunction

endpackage

@@ rtl/rtc_bcd_time_check_decode.sv @@
// ----------------------------------------------------------------------------
// rtc_bcd_time_check_decode
// Checks one RTC register snapshot and decodes it to binary date and time.
// ----------------------------------------------------------------------------
// Each snap transaction carries the bus flags, the status byte and the seven
// raw BCD time registers of a real-time clock. The block masks the control
// bits, checks every digit against the range of its field (date and month
// must be non-zero, 12-hour mode is refused), and returns one result
// transaction holding a priority status code, a valid flag and the binary
// year, month, date, hour, minute and second (all zero when not valid).
// The snapshot is captured in an input register, and the decoded result is
// held in an output register until taken. Both stages advance
// independently, so one transaction is accepted every cycle while the
// result side keeps up; snap_ready drops only when both registers are
// full and result_ready is low.
// ----------------------------------------------------------------------------
module rtc_bcd_time_check_decode (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                snap_valid,
	output logic                snap_ready,
	input  rbtd_pkg::rbtd_in_t  snap,
	output logic                result_valid,
	input  logic                result_ready,
	output rbtd_pkg::rbtd_out_t result
);
	import rbtd_pkg::*;

	logic      valid_s1;
	rbtd_in_t  snap_s1;
	logic      valid_s2;
	rbtd_out_t result_s2;
	rbtd_out_t dec;
	logic      s2_ready;
	logic      s1_ready;

	// output stage frees up when empty or when its transaction is taken
	assign s2_ready   = !valid_s2 || result_ready;
	// input stage frees up when empty or when it moves into the output stage
	assign s1_ready   = !valid_s1 || s2_ready;
	assign snap_ready = s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= snap_valid;
			end
			if (s2_ready) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (snap_valid && s1_ready) begin
			snap_s1 <= snap;
		end
		if (valid_s1 && s2_ready) begin
			result_s2 <= dec;
		end
	end

	// all checking and conversion sits between the two registers
	rbtd_decode u_decode (
		.snap   (snap_s1),
		.result (dec)
	);

	assign result_valid = valid_s2;
	assign result       = result_s2;

endmodule

@@ rtl/rbtd_decode.sv @@
// ----------------------------------------------------------------------------
// rbtd_decode
// Field masking, BCD range checks, binary conversion and status priority.
// ----------------------------------------------------------------------------
module rbtd_decode (
	input  rbtd_pkg::rbtd_in_t  snap,
	output rbtd_pkg::rbtd_out_t result
);
	import rbtd_pkg::*;

	logic [7:0] sec;
	logic [7:0] min;
	logic [7:0] hrs;
	logic [7:0] wday;
	logic [7:0] date;
	logic [7:0] mon;
	logic [7:0] year;
	logic       twelve;
	logic       dec_ok;
	logic       valid;
	logic [7:0] year_bin;
	logic [7:0] mon_bin;
	logic [7:0] date_bin;
	logic [7:0] hrs_bin;
	logic [7:0] min_bin;
	logic [7:0] sec_bin;

	// masks drop the control bits each register carries
	assign sec    = {1'b0, snap.seconds_raw[6:0]};
	assign min    = {1'b0, snap.minutes_raw[6:0]};
	assign hrs    = {2'b00, snap.hours_raw[5:0]};
	assign wday   = {5'b00000, snap.weekday_raw[2:0]};
	assign date   = {2'b00, snap.date_raw[5:0]};
	assign mon    = {3'b000, snap.month_raw[4:0]};
	assign year   = snap.year_raw;
	assign twelve = snap.hours_raw[6];

	assign year_bin = bcd_value(year);
	assign mon_bin  = bcd_value(mon);
	assign date_bin = bcd_value(date);
	assign hrs_bin  = bcd_value(hrs);
	assign min_bin  = bcd_value(min);
	assign sec_bin  = bcd_value(sec);

	assign dec_ok = bcd_ok(sec, 4'd5, 8'd59) && bcd_ok(min, 4'd5, 8'd59) && !twelve &&
		bcd_ok(hrs, 4'd2, 8'd23) && bcd_ok(wday, 4'd0, 8'd7) &&
		bcd_ok(date, 4'd3, 8'd31) && (date_bin != 8'd0) &&
		bcd_ok(mon, 4'd1, 8'd12) && (mon_bin != 8'd0) &&
		bcd_ok(year, 4'd9, 8'd99);

	assign valid = snap.device_present && snap.time_read_ok && dec_ok;

	always_comb begin
		result = '0;
		if (!snap.device_present) begin
			result.status_code = ST_ABSENT;
		end else if (!(snap.status_read_ok && snap.time_read_ok)) begin
			result.status_code = ST_READ_ERR;
		end else if (snap.status_byte[7]) begin
			result.status_code = ST_OSC_STOP;
		end else if (twelve) begin
			result.status_code = ST_12H_MODE;
		end else if (!dec_ok) begin
			result.status_code = ST_DEC_ERR;
		end else begin
			result.status_code = ST_OK;
		end
		result.time_valid = valid;
		if (valid) begin
			result.year_out   = YEAR_BASE + {4'b0000, year_bin};
			result.month_out  = mon_bin[3:0];
			result.date_out   = date_bin[4:0];
			result.hour_out   = hrs_bin[4:0];
			result.minute_out = min_bin[5:0];
			result.second_out = sec_bin[5:0];
		end
	end

endmodule

@@ rtl/rbtd_checker.sv @@
// ----------------------------------------------------------------------------
// rbtd_checker
// Port-level checks on the result channel of the decoder, bound to the top.
// ----------------------------------------------------------------------------
module rbtd_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                snap_ready,
	input logic                result_valid,
	input logic                result_ready,
	input rbtd_pkg::rbtd_out_t result
);
	import rbtd_pkg::*;

	logic fields_zero;

	assign fields_zero = (result.year_out == '0) && (result.month_out == '0) &&
		(result.date_out == '0) && (result.hour_out == '0) &&
		(result.minute_out == '0) && (result.second_out == '0);

	// a stalled result holds its payload
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// time fields are zero unless the time is valid
	a_zero_when_invalid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.time_valid |-> fields_zero)
		else $error("time fields set on invalid result");

	// a valid time is only seen with read error, oscillator stop or good status
	a_valid_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.time_valid |->
			(result.status_code == ST_READ_ERR) || (result.status_code == ST_OSC_STOP) ||
			(result.status_code == ST_OK))
		else $error("valid time with inconsistent status");

	// good status always comes with a decoded time inside its range
	a_ok_means_valid: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.status_code == ST_OK) |->
			result.time_valid && (result.month_out != '0) && (result.date_out != '0) &&
			(result.hour_out <= 5'd23) && (result.year_out >= YEAR_BASE))
		else $error("good status without a sound time");

	// the input side never stalls while the result side is free
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!result_valid |-> snap_ready)
		else $error("snapshot refused with empty output");

endmodule

bind rtc_bcd_time_check_decode rbtd_checker u_rbtd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.snap_ready   (snap_ready),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
